### rtl/skyal_pkg.sv
`default_nettype none

package skyal_pkg;

  localparam int RECT_W = 9;
  localparam int POS_W  = 8;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_FWD   = 6'b000100,
    ST_BWD   = 6'b001000,
    ST_WRITE = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

endpackage

`default_nettype wire

### rtl/skyal_ram.sv
`default_nettype none

module skyal_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/skyline_atlas_allocator_unit.sv
// Skyline atlas allocator.
//
// A request word on the in_ channel carries a rectangle width and height.
// One result word leaves on the out_ channel for every request: placed, the
// page index and the top-left corner, or placed low when no page has room.
// Pages are tried in order; on each page the leftmost position with the
// lowest skyline under the rectangle is chosen and its columns are raised.
//
// Each page costs a forward pass that builds block prefix maxima in a
// scratch memory and a backward pass that scores every position; the
// placement write then raises the rect_width chosen columns, and the
// result word is loaded last. A request with a zero size or a width above
// PAGE_WIDTH skips the passes and is answered as not placed. Requests are
// taken one at a time.
//
// After reset all NUM_PAGES * PAGE_WIDTH entries of the column-fill memory
// are cleared, one entry per cycle, before the first request is accepted.
// A finished result waits in the output register while out_stall is high;
// a new request may be accepted meanwhile but its result is held back until
// the register is free.
`default_nettype none

module skyline_atlas_allocator_unit
  import skyal_pkg::*;
#(
  parameter int NUM_PAGES   = 2,
  parameter int PAGE_WIDTH  = 256,
  parameter int PAGE_HEIGHT = 256
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [RECT_W-1:0] in_rect_width,
  input  wire logic [RECT_W-1:0] in_rect_height,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_placed,
  output logic                   out_page,
  output logic [POS_W-1:0]       out_pos_x,
  output logic [POS_W-1:0]       out_pos_y
);

  localparam int DEPTH = NUM_PAGES * PAGE_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(PAGE_WIDTH);
  localparam int CW    = $clog2(PAGE_WIDTH + 1);
  localparam int HW    = $clog2(PAGE_HEIGHT + 1);
  localparam int PW    = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int SW    = ((HW > RECT_W) ? HW : RECT_W) + 1;
  localparam int WCW   = ((CW > RECT_W) ? CW : RECT_W);

  state_t              state_r, state_nxt;
  logic [AW-1:0]       clr_r, clr_nxt;
  logic [AW-1:0]       base_r, base_nxt;
  logic [PW-1:0]       page_r, page_nxt;
  logic [CW-1:0]       w_r, w_nxt;
  logic [RECT_W-1:0]   h_r, h_nxt;
  logic [CW-1:0]       lim_r, lim_nxt;
  logic [XW-1:0]       rd_col_r, rd_col_nxt;
  logic                iss_busy_r, iss_busy_nxt;
  logic                v1_r, v1_nxt;
  logic [XW-1:0]       col1_r, col1_nxt;
  logic [XW-1:0]       blk_r, blk_nxt;
  logic [HW-1:0]       pacc_r, pacc_nxt;
  logic [HW-1:0]       sacc_r, sacc_nxt;
  logic [HW-1:0]       best_y_r, best_y_nxt;
  logic [XW-1:0]       best_x_r, best_x_nxt;
  logic [XW-1:0]       wr_k_r, wr_k_nxt;
  logic                placed_r, placed_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_placed_r, out_placed_nxt;
  logic                out_page_r, out_page_nxt;
  logic [POS_W-1:0]    out_pos_x_r, out_pos_x_nxt;
  logic [POS_W-1:0]    out_pos_y_r, out_pos_y_nxt;

  logic                fill_we;
  logic [AW-1:0]       fill_waddr;
  logic [HW-1:0]       fill_wdata;
  logic [AW-1:0]       fill_raddr;
  logic [HW-1:0]       fill_rdata;
  logic                scr_we;
  logic [HW-1:0]       scr_wdata;
  logic                flag_wdata;
  logic [XW-1:0]       scr_raddr;
  logic [HW-1:0]       scr_rdata;
  logic                flag_rdata;

  logic [SW-1:0]       ysum;
  logic [SW-1:0]       ysum_new;
  logic                blk_last;
  logic [HW-1:0]       pnew;
  logic [HW-1:0]       snew;
  logic [HW-1:0]       score;
  logic                upd;
  logic [HW-1:0]       best_y_new;
  logic [XW-1:0]       best_x_new;
  logic [CW:0]         pa_sum;
  logic [31:0]         x_ext;
  logic [31:0]         y_ext;
  logic [31:0]         pg_ext;

  skyal_ram #(.WIDTH(HW), .DEPTH(DEPTH)) u_fill_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_waddr),
    .wdata (fill_wdata),
    .raddr (fill_raddr),
    .rdata (fill_rdata)
  );

  skyal_ram #(.WIDTH(HW), .DEPTH(PAGE_WIDTH)) u_pmax_ram (
    .clk   (clk),
    .we    (scr_we),
    .waddr (col1_r),
    .wdata (scr_wdata),
    .raddr (scr_raddr),
    .rdata (scr_rdata)
  );

  skyal_ram #(.WIDTH(1), .DEPTH(PAGE_WIDTH)) u_flag_ram (
    .clk   (clk),
    .we    (scr_we),
    .waddr (col1_r),
    .wdata (flag_wdata),
    .raddr (rd_col_r),
    .rdata (flag_rdata)
  );

  assign in_stall   = (state_r != ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_placed = out_placed_r;
  assign out_page   = out_page_r;
  assign out_pos_x  = out_pos_x_r;
  assign out_pos_y  = out_pos_y_r;

  assign fill_raddr = base_r + AW'(rd_col_r);
  assign ysum       = SW'(best_y_r) + SW'(h_r);

  always_comb begin
    blk_last   = (CW'(blk_r) == (w_r - CW'(1))) || (col1_r == XW'(PAGE_WIDTH - 1));
    pnew       = ((blk_r == '0) || (fill_rdata > pacc_r)) ? fill_rdata : pacc_r;
    scr_wdata  = pnew;
    flag_wdata = blk_last;
    scr_we     = (state_r == ST_FWD) && v1_r;

    pa_sum    = (CW+1)'(rd_col_r) + (CW+1)'(w_r) - (CW+1)'(1);
    scr_raddr = (CW'(rd_col_r) <= lim_r) ? XW'(pa_sum) : '0;

    snew       = (flag_rdata || (fill_rdata > sacc_r)) ? fill_rdata : sacc_r;
    score      = (scr_rdata > snew) ? scr_rdata : snew;
    upd        = (CW'(col1_r) <= lim_r) && (score <= best_y_r);
    best_y_new = upd ? score : best_y_r;
    best_x_new = upd ? col1_r : best_x_r;
    ysum_new   = SW'(best_y_new) + SW'(h_r);

    fill_we    = 1'b0;
    fill_waddr = clr_r;
    fill_wdata = '0;
    if (state_r == ST_CLEAR) begin
      fill_we = 1'b1;
    end else if (state_r == ST_WRITE) begin
      fill_we    = 1'b1;
      fill_waddr = base_r + AW'(best_x_r) + AW'(wr_k_r);
      fill_wdata = HW'(ysum);
    end

    x_ext  = 32'(best_x_r);
    y_ext  = 32'(best_y_r);
    pg_ext = 32'(page_r);
  end

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    base_nxt       = base_r;
    page_nxt       = page_r;
    w_nxt          = w_r;
    h_nxt          = h_r;
    lim_nxt        = lim_r;
    rd_col_nxt     = rd_col_r;
    iss_busy_nxt   = iss_busy_r;
    v1_nxt         = iss_busy_r && ((state_r == ST_FWD) || (state_r == ST_BWD));
    col1_nxt       = rd_col_r;
    blk_nxt        = blk_r;
    pacc_nxt       = pacc_r;
    sacc_nxt       = sacc_r;
    best_y_nxt     = best_y_r;
    best_x_nxt     = best_x_r;
    wr_k_nxt       = wr_k_r;
    placed_nxt     = placed_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_placed_nxt = out_placed_r;
    out_page_nxt   = out_page_r;
    out_pos_x_nxt  = out_pos_x_r;
    out_pos_y_nxt  = out_pos_y_r;

    if (iss_busy_r) begin
      if (state_r == ST_FWD) begin
        if (rd_col_r == XW'(PAGE_WIDTH - 1)) begin
          iss_busy_nxt = 1'b0;
        end else begin
          rd_col_nxt = rd_col_r + XW'(1);
        end
      end else if (state_r == ST_BWD) begin
        if (rd_col_r == '0) begin
          iss_busy_nxt = 1'b0;
        end else begin
          rd_col_nxt = rd_col_r - XW'(1);
        end
      end
    end

    case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          w_nxt        = CW'(in_rect_width);
          h_nxt        = in_rect_height;
          lim_nxt      = CW'(PAGE_WIDTH) - CW'(in_rect_width);
          page_nxt     = '0;
          base_nxt     = '0;
          rd_col_nxt   = '0;
          blk_nxt      = '0;
          iss_busy_nxt = 1'b1;
          state_nxt    = ST_FWD;
          if ((in_rect_width == '0) || (in_rect_height == '0) ||
              (WCW'(in_rect_width) > WCW'(PAGE_WIDTH))) begin
            iss_busy_nxt = 1'b0;
            placed_nxt   = 1'b0;
            state_nxt    = ST_DONE;
          end
        end
      end
      ST_FWD: begin
        if (v1_r) begin
          pacc_nxt = pnew;
          blk_nxt  = blk_last ? '0 : blk_r + XW'(1);
          if (col1_r == XW'(PAGE_WIDTH - 1)) begin
            state_nxt    = ST_BWD;
            rd_col_nxt   = XW'(PAGE_WIDTH - 1);
            iss_busy_nxt = 1'b1;
            best_y_nxt   = '1;
          end
        end
      end
      ST_BWD: begin
        if (v1_r) begin
          sacc_nxt   = snew;
          best_y_nxt = best_y_new;
          best_x_nxt = best_x_new;
          if (col1_r == '0) begin
            if (ysum_new <= SW'(PAGE_HEIGHT)) begin
              wr_k_nxt  = '0;
              state_nxt = ST_WRITE;
            end else if (page_r == PW'(NUM_PAGES - 1)) begin
              placed_nxt = 1'b0;
              state_nxt  = ST_DONE;
            end else begin
              page_nxt     = page_r + PW'(1);
              base_nxt     = base_r + AW'(PAGE_WIDTH);
              rd_col_nxt   = '0;
              blk_nxt      = '0;
              iss_busy_nxt = 1'b1;
              state_nxt    = ST_FWD;
            end
          end
        end
      end
      ST_WRITE: begin
        wr_k_nxt = wr_k_r + XW'(1);
        if (CW'(wr_k_r) == (w_r - CW'(1))) begin
          placed_nxt = 1'b1;
          state_nxt  = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_placed_nxt = placed_r;
          out_page_nxt   = placed_r ? pg_ext[0] : 1'b0;
          out_pos_x_nxt  = placed_r ? x_ext[POS_W-1:0] : '0;
          out_pos_y_nxt  = placed_r ? y_ext[POS_W-1:0] : '0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      iss_busy_r  <= 1'b0;
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      iss_busy_r  <= iss_busy_nxt;
      v1_r        <= v1_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r       <= base_nxt;
    page_r       <= page_nxt;
    w_r          <= w_nxt;
    h_r          <= h_nxt;
    lim_r        <= lim_nxt;
    rd_col_r     <= rd_col_nxt;
    col1_r       <= col1_nxt;
    blk_r        <= blk_nxt;
    pacc_r       <= pacc_nxt;
    sacc_r       <= sacc_nxt;
    best_y_r     <= best_y_nxt;
    best_x_r     <= best_x_nxt;
    wr_k_r       <= wr_k_nxt;
    placed_r     <= placed_nxt;
    out_placed_r <= out_placed_nxt;
    out_page_r   <= out_page_nxt;
    out_pos_x_r  <= out_pos_x_nxt;
    out_pos_y_r  <= out_pos_y_nxt;
  end

  a_fill_height_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_we |-> (SW'(fill_wdata) <= SW'(PAGE_HEIGHT)))
    else $error("column fill written above the page height");

  a_write_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE) |-> (ysum <= SW'(PAGE_HEIGHT)))
    else $error("placement written that does not fit the page");

  a_write_in_page: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE) |->
      ((CW+1)'(best_x_r) + (CW+1)'(wr_k_r) < (CW+1)'(PAGE_WIDTH)))
    else $error("placement write runs past the page edge");

  a_read_data_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> ((state_r == ST_FWD) || (state_r == ST_BWD)))
    else $error("column read returned outside a scan pass");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !out_valid_r)
    else $error("result word produced during the clearing pass");

endmodule

`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 100ps

import skyal_pkg::*;

localparam int ATLAS_PAGES = 2;
localparam int ATLAS_COLS  = 256;
localparam int ATLAS_ROWS  = 256;

typedef struct packed {
  logic             placed;
  logic             page;
  logic [POS_W-1:0] pos_x;
  logic [POS_W-1:0] pos_y;
} placement_t;

class placement_checker;
  int unsigned skyline [ATLAS_PAGES][ATLAS_COLS];
  placement_t  pending_placements [$];
  int unsigned mismatches;

  function new();
    foreach (skyline[p, c]) skyline[p][c] = 0;
    mismatches = 0;
  endfunction

  // Pages are tried in order; the leftmost window with the lowest peak wins.
  function placement_t place_rect(int unsigned w, int unsigned h);
    placement_t  res;
    int unsigned best_x;
    int unsigned best_y;
    int unsigned peak;
    bit          found;
    res = '0;
    if (w == 0 || h == 0 || w > ATLAS_COLS) return res;
    for (int p = 0; p < ATLAS_PAGES; p++) begin
      found  = 1'b0;
      best_x = 0;
      best_y = 0;
      for (int unsigned x = 0; x + w <= ATLAS_COLS; x++) begin
        peak = 0;
        for (int unsigned k = 0; k < w; k++) begin
          if (skyline[p][x + k] > peak) peak = skyline[p][x + k];
        end
        if (!found || peak < best_y) begin
          found  = 1'b1;
          best_y = peak;
          best_x = x;
        end
      end
      if (found && best_y + h <= ATLAS_ROWS) begin
        for (int unsigned k = 0; k < w; k++) skyline[p][best_x + k] = best_y + h;
        res.placed = 1'b1;
        res.page   = p[0];
        res.pos_x  = best_x[POS_W-1:0];
        res.pos_y  = best_y[POS_W-1:0];
        return res;
      end
    end
    return res;
  endfunction

  function void note_request(logic [RECT_W-1:0] w, logic [RECT_W-1:0] h);
    pending_placements.push_back(place_rect(w, h));
  endfunction

  task report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatches++;
  endtask

  task compare_field(string name, int unsigned got, int unsigned want);
    if (got != want) report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  task check_result(placement_t got);
    placement_t want;
    if (pending_placements.size() == 0) begin
      report_mismatch($sformatf("result word with no request waiting: placed=%0d page=%0d x=%0d y=%0d",
                                got.placed, got.page, got.pos_x, got.pos_y));
      return;
    end
    want = pending_placements.pop_front();
    compare_field("placed", got.placed, want.placed);
    compare_field("page", got.page, want.page);
    compare_field("pos_x", got.pos_x, want.pos_x);
    compare_field("pos_y", got.pos_y, want.pos_y);
  endtask
endclass

module tb_top;
  localparam int RANDOM_ITEMS = 566;
  localparam int IDLE_LIMIT   = 20000;
  localparam int DRAIN_CYCLES = 1200;

  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              in_valid       = 1'b0;
  logic              in_stall;
  logic [RECT_W-1:0] in_rect_width  = '0;
  logic [RECT_W-1:0] in_rect_height = '0;
  logic              out_valid;
  logic              out_stall      = 1'b0;
  logic              out_placed;
  logic              out_page;
  logic [POS_W-1:0]  out_pos_x;
  logic [POS_W-1:0]  out_pos_y;

  placement_checker board;
  placement_t       seen;
  bit               quiet = 1'b0;
  int               idle_cycles = 0;
  bit               moved;

  int unsigned dir_w [14] = '{0, 5, 257, 511, 1, 256, 255, 1, 1, 256, 128, 128, 2, 16};
  int unsigned dir_h [14] = '{5, 0, 1, 511, 257, 1, 10, 5, 256, 256, 16, 16, 240, 256};

  skyline_atlas_allocator_unit #(
    .NUM_PAGES  (ATLAS_PAGES),
    .PAGE_WIDTH (ATLAS_COLS),
    .PAGE_HEIGHT(ATLAS_ROWS)
  ) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_rect_width (in_rect_width),
    .in_rect_height(in_rect_height),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_placed    (out_placed),
    .out_page      (out_page),
    .out_pos_x     (out_pos_x),
    .out_pos_y     (out_pos_y)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    moved = 1'b0;
    if (rst_n) begin
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        board.note_request(in_rect_width, in_rect_height);
        moved = 1'b1;
      end
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        seen.placed = out_placed;
        seen.page   = out_page;
        seen.pos_x  = out_pos_x;
        seen.pos_y  = out_pos_y;
        board.check_result(seen);
        moved = 1'b1;
      end
    end
    if (moved) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("skyline_atlas_allocator_unit verification failed");
      $finish;
    end
  end

  initial begin
    forever begin
      if (quiet || $urandom_range(0, 1) == 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
    end
  end

  // The word stays on the port until it is taken; a gap may follow it.
  task automatic offer_rect(input int unsigned w, input int unsigned h);
    in_valid       <= 1'b1;
    in_rect_width  <= w[RECT_W-1:0];
    in_rect_height <= h[RECT_W-1:0];
    do @(posedge clk); while (in_stall !== 1'b0);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  initial begin
    int unsigned w;
    int unsigned h;
    int unsigned pick;
    board = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    foreach (dir_w[i]) offer_rect(dir_w[i], dir_h[i]);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i >= RANDOM_ITEMS * 9 / 10) quiet = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        w = $urandom_range(1, 32);
        h = $urandom_range(1, 32);
      end else if (pick < 88) begin
        w = $urandom_range(1, 256);
        h = $urandom_range(1, 64);
      end else if (pick < 94) begin
        w = $urandom_range(1, 64);
        h = $urandom_range(1, 256);
      end else begin
        w = $urandom_range(0, 511);
        h = $urandom_range(0, 511);
      end
      offer_rect(w, h);
    end
    in_valid <= 1'b0;
    while (board.pending_placements.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("skyline_atlas_allocator_unit verification clean");
    end else begin
      $display("skyline_atlas_allocator_unit verification failed");
    end
    $finish;
  end
endmodule

### filelist.f
rtl/skyal_pkg.sv
rtl/skyal_ram.sv
rtl/skyline_atlas_allocator_unit.sv
sim/tb_top.sv
